// ===== sv/pls_pkg.sv =====
// Shared types, codes and default parameters of the positional list stack.
package pls_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [3:0] {
    K_PUSH     = 4'd0,
    K_APPEND   = 4'd1,
    K_INSERT   = 4'd2,
    K_POP      = 4'd3,
    K_DEL_END  = 4'd4,
    K_DEL_AT   = 4'd5,
    K_FIND     = 4'd6,
    K_PEEK     = 4'd7,
    K_DUMP     = 4'd8
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] value;
    logic        [4:0]  position;
  } request_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] data_out;
    logic        [4:0]  index_out;
    logic        [4:0]  entry_count;
    logic               last;
  } result_t;

  typedef struct packed {
    logic load_new;
    logic from_left;
    logic from_right;
  } cell_ctl_t;

endpackage

// ===== sv/pls_cell.sv =====
// One list cell: holds a word, shifts toward either neighbor and compares against the key.
module pls_cell #(
  parameter int DATA_WIDTH = pls_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  pls_pkg::cell_ctl_t    ctl,
  input  logic [DATA_WIDTH-1:0] new_word,
  input  logic [DATA_WIDTH-1:0] left_word,
  input  logic [DATA_WIDTH-1:0] right_word,
  input  logic [DATA_WIDTH-1:0] key,
  output logic [DATA_WIDTH-1:0] word,
  output logic                  match
);

  logic [DATA_WIDTH-1:0] word_r;

  always_ff @(posedge clk) begin
    priority if (ctl.load_new) begin
      word_r <= new_word;
    end else if (ctl.from_left) begin
      word_r <= left_word;
    end else if (ctl.from_right) begin
      word_r <= right_word;
    end else begin
      word_r <= word_r;
    end
  end

  assign word  = word_r;
  assign match = (word_r == key);

endmodule

// ===== sv/positional_list_stack_core.sv =====
// Top level of the positional list stack: cell chain, operation decode and result scan.
//
// The list lives in a chain of CAPACITY cells that shift toward the back on an insert and
// toward the front on a delete, so push, append, insert at, pop, delete end, delete at and
// peek each give one result without a scan. Find scans the cells front first through a
// single read selector, one entry per cycle while the output is free; dump gives one
// result per cycle on the same condition, one per entry. The request side stalls while
// a scan runs and whenever the output register holds a result that is not being taken.
module positional_list_stack_core #(
  parameter int CAPACITY   = pls_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = pls_pkg::DATA_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pls_pkg::request_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pls_pkg::result_t  out_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int PW = ((CW > 5) ? CW : 5) + 1;
  localparam int EW = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t            state_r;
  logic [CW-1:0]     count_r;
  logic [IW-1:0]     idx_r;
  logic [DATA_WIDTH-1:0] key_r;
  logic              scan_find_r;
  logic              out_valid_r;
  pls_pkg::result_t  out_r;

  logic [DATA_WIDTH-1:0] words [CAPACITY];
  logic [CAPACITY-1:0]   match;
  pls_pkg::cell_ctl_t    ctl [CAPACITY];

  logic                  out_free;
  logic                  acc;
  logic signed [EW-1:0]  value_ext;
  logic [DATA_WIDTH-1:0] in_word;

  logic                  op_ins;
  logic                  op_del;
  logic [IW-1:0]         slot;
  logic [PW-1:0]         tpos;
  logic [PW-1:0]         pos_x;
  logic [PW-1:0]         cnt_x;
  pls_pkg::status_t      op_status;
  logic [DATA_WIDTH-1:0] op_word;
  logic                  emit_now;
  logic                  start_scan;
  logic [CW-1:0]         cnt_nxt;
  logic                  full;
  logic                  empty;

  logic [DATA_WIDTH-1:0] cur_word;
  logic                  cur_match;
  logic [CW-1:0]         idx_inc;
  logic                  idx_last;

  function automatic pls_pkg::result_t mk_result(pls_pkg::status_t st,
                                                 logic [DATA_WIDTH-1:0] w,
                                                 logic [4:0] idx,
                                                 logic [4:0] cnt,
                                                 logic lst);
    pls_pkg::result_t r;
    logic [EW-1:0]    wx;
    wx            = EW'(w);
    r.status      = st;
    r.data_out    = wx[31:0];
    r.index_out   = idx;
    r.entry_count = cnt;
    r.last        = lst;
    return r;
  endfunction

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !out_free;
  assign acc       = in_valid && !in_stall;
  assign value_ext = EW'(in_data.value);
  assign in_word   = value_ext[DATA_WIDTH-1:0];

  assign full  = (count_r == CW'(CAPACITY));
  assign empty = (count_r == '0);
  assign pos_x = PW'(in_data.position);
  assign cnt_x = PW'(count_r);

  always_comb begin
    op_ins     = 1'b0;
    op_del     = 1'b0;
    slot       = '0;
    tpos       = '0;
    op_status  = pls_pkg::ST_OK;
    op_word    = '0;
    emit_now   = 1'b1;
    start_scan = 1'b0;
    unique case (in_data.kind)
      pls_pkg::K_PUSH, pls_pkg::K_APPEND, pls_pkg::K_INSERT: begin
        if (in_data.kind == pls_pkg::K_PUSH) begin
          tpos = PW'(1);
        end else if (in_data.kind == pls_pkg::K_APPEND) begin
          tpos = cnt_x + PW'(1);
        end else begin
          tpos = pos_x;
        end
        if (full) begin
          op_status = pls_pkg::ST_FULL;
        end else if (tpos == '0 || tpos > cnt_x + PW'(1)) begin
          op_status = pls_pkg::ST_BADPOS;
        end else begin
          op_ins = 1'b1;
          slot   = IW'(tpos - PW'(1));
        end
      end
      pls_pkg::K_POP, pls_pkg::K_DEL_END, pls_pkg::K_DEL_AT: begin
        if (in_data.kind == pls_pkg::K_POP) begin
          tpos = PW'(1);
        end else if (in_data.kind == pls_pkg::K_DEL_END) begin
          tpos = cnt_x;
        end else begin
          tpos = pos_x;
        end
        if (empty) begin
          op_status = pls_pkg::ST_EMPTY;
        end else if (tpos == '0 || tpos > cnt_x) begin
          op_status = pls_pkg::ST_BADPOS;
        end else begin
          op_del  = 1'b1;
          slot    = IW'(tpos - PW'(1));
          op_word = words[slot];
        end
      end
      pls_pkg::K_FIND: begin
        if (empty) begin
          op_status = pls_pkg::ST_NOTFOUND;
        end else begin
          emit_now   = 1'b0;
          start_scan = 1'b1;
        end
      end
      pls_pkg::K_PEEK: begin
        if (empty) begin
          op_status = pls_pkg::ST_EMPTY;
        end else begin
          op_word = words[0];
        end
      end
      pls_pkg::K_DUMP: begin
        if (empty) begin
          op_status = pls_pkg::ST_EMPTY;
        end else begin
          emit_now   = 1'b0;
          start_scan = 1'b1;
        end
      end
      default: begin
        op_status = pls_pkg::ST_BADPOS;
      end
    endcase
  end

  always_comb begin
    cnt_nxt = count_r;
    if (op_ins) begin
      cnt_nxt = count_r + CW'(1);
    end else if (op_del) begin
      cnt_nxt = count_r - CW'(1);
    end
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w;
    logic [DATA_WIDTH-1:0] right_w;

    if (k == 0) begin : g_first
      assign left_w = in_word;
    end else begin : g_mid_l
      assign left_w = words[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign right_w = words[k];
    end else begin : g_mid_r
      assign right_w = words[k+1];
    end

    assign ctl[k].load_new   = acc && op_ins && (IW'(k) == slot);
    assign ctl[k].from_left  = acc && op_ins && (IW'(k) > slot);
    assign ctl[k].from_right = acc && op_del && (IW'(k) >= slot);

    pls_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl[k]),
      .new_word  (in_word),
      .left_word (left_w),
      .right_word(right_w),
      .key       (key_r),
      .word      (words[k]),
      .match     (match[k])
    );
  end

  assign cur_word  = words[idx_r];
  assign cur_match = match[idx_r];
  assign idx_inc   = CW'(idx_r) + CW'(1);
  assign idx_last  = (idx_inc == count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (acc) begin
            count_r     <= cnt_nxt;
            key_r       <= in_word;
            idx_r       <= '0;
            scan_find_r <= (in_data.kind == pls_pkg::K_FIND);
            if (start_scan) begin
              state_r <= S_SCAN;
            end
            if (emit_now) begin
              out_valid_r <= 1'b1;
              out_r       <= mk_result(op_status, op_word, 5'd0, 5'(cnt_nxt), 1'b1);
            end
          end
        end
        S_SCAN: begin
          if (out_free) begin
            if (!scan_find_r) begin
              out_valid_r <= 1'b1;
              out_r       <= mk_result(pls_pkg::ST_OK, cur_word, 5'(idx_inc),
                                       5'(count_r), idx_last);
              if (idx_last) begin
                state_r <= S_IDLE;
              end else begin
                idx_r <= idx_r + IW'(1);
              end
            end else if (cur_match) begin
              out_valid_r <= 1'b1;
              out_r       <= mk_result(pls_pkg::ST_OK, cur_word, 5'(idx_inc),
                                       5'(count_r), 1'b1);
              state_r     <= S_IDLE;
            end else if (idx_last) begin
              out_valid_r <= 1'b1;
              out_r       <= mk_result(pls_pkg::ST_NOTFOUND, '0, 5'd0,
                                       5'(count_r), 1'b1);
              state_r     <= S_IDLE;
            end else begin
              idx_r <= idx_r + IW'(1);
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_scan_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |=> (count_r == $past(count_r)))
    else $error("entry count changed during a scan");

  a_partial_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.last) |-> (state_r == S_SCAN))
    else $error("non-final result outside of a dump");

  a_result_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.entry_count == 5'(count_r)))
    else $error("result entry count disagrees with the list");

endmodule

// ===== sim/tb_positional_list_stack_core.sv =====
// Self-checking testbench for positional_list_stack_core against a shadow list.
`timescale 1ns / 1ps

module tb_positional_list_stack_core;

  localparam int LIST_DEPTH = pls_pkg::CAPACITY_DEF;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  pls_pkg::request_t in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  pls_pkg::result_t  out_data;

  logic signed [31:0] shadow_list [LIST_DEPTH];
  int                 shadow_count = 0;
  pls_pkg::result_t   awaited_results [$];

  int mismatches = 0;
  int idle_cycles = 0;
  bit gaps_on = 1'b0;
  int burst_left = 0;
  int hold_request = 0;
  int hold_left = 0;
  int stall_tick = 0;

  positional_list_stack_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  function automatic pls_pkg::request_t make_req(pls_pkg::kind_t k, logic signed [31:0] v,
                                                 logic [4:0] p);
    pls_pkg::request_t req;
    req.kind = k;
    req.value = v;
    req.position = p;
    return req;
  endfunction

  // Updates the shadow list for one accepted request and queues the results it causes.
  function automatic void apply_list_op(pls_pkg::request_t req);
    pls_pkg::result_t r;
    int               pos;
    int               hit;
    r = '0;
    r.status = pls_pkg::ST_OK;
    r.last = 1'b1;
    pos = req.position;
    case (req.kind)
      pls_pkg::K_PUSH, pls_pkg::K_APPEND, pls_pkg::K_INSERT: begin
        if (req.kind == pls_pkg::K_PUSH) begin
          pos = 1;
        end else if (req.kind == pls_pkg::K_APPEND) begin
          pos = shadow_count + 1;
        end
        if (shadow_count >= LIST_DEPTH) begin
          r.status = pls_pkg::ST_FULL;
        end else if (pos < 1 || pos > shadow_count + 1) begin
          r.status = pls_pkg::ST_BADPOS;
        end else begin
          for (int i = shadow_count; i > pos - 1; i--) shadow_list[i] = shadow_list[i - 1];
          shadow_list[pos - 1] = req.value;
          shadow_count++;
        end
        r.entry_count = 5'(shadow_count);
        awaited_results.push_back(r);
      end
      pls_pkg::K_POP, pls_pkg::K_DEL_END, pls_pkg::K_DEL_AT: begin
        if (req.kind == pls_pkg::K_POP) begin
          pos = 1;
        end else if (req.kind == pls_pkg::K_DEL_END) begin
          pos = shadow_count;
        end
        if (shadow_count == 0) begin
          r.status = pls_pkg::ST_EMPTY;
        end else if (pos < 1 || pos > shadow_count) begin
          r.status = pls_pkg::ST_BADPOS;
        end else begin
          r.data_out = shadow_list[pos - 1];
          for (int i = pos - 1; i < shadow_count - 1; i++) shadow_list[i] = shadow_list[i + 1];
          shadow_count--;
        end
        r.entry_count = 5'(shadow_count);
        awaited_results.push_back(r);
      end
      pls_pkg::K_FIND: begin
        hit = 0;
        for (int i = 0; i < shadow_count; i++) begin
          if (hit == 0 && shadow_list[i] == req.value) hit = i + 1;
        end
        if (hit == 0) begin
          r.status = pls_pkg::ST_NOTFOUND;
        end else begin
          r.data_out = shadow_list[hit - 1];
          r.index_out = 5'(hit);
        end
        r.entry_count = 5'(shadow_count);
        awaited_results.push_back(r);
      end
      pls_pkg::K_PEEK: begin
        if (shadow_count == 0) begin
          r.status = pls_pkg::ST_EMPTY;
        end else begin
          r.data_out = shadow_list[0];
        end
        r.entry_count = 5'(shadow_count);
        awaited_results.push_back(r);
      end
      pls_pkg::K_DUMP: begin
        r.entry_count = 5'(shadow_count);
        if (shadow_count == 0) begin
          r.status = pls_pkg::ST_EMPTY;
          awaited_results.push_back(r);
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            r.data_out = shadow_list[i];
            r.index_out = 5'(i + 1);
            r.last = (i + 1 == shadow_count);
            awaited_results.push_back(r);
          end
        end
      end
      default: begin
        r.status = pls_pkg::ST_BADPOS;
        r.entry_count = 5'(shadow_count);
        awaited_results.push_back(r);
      end
    endcase
  endfunction

  task automatic send_request(input pls_pkg::request_t req);
    int gap;
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_list_op(req);
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 12);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  task automatic test_empty_list();
    send_request(make_req(pls_pkg::K_PEEK, 32'd0, 5'd0));
    send_request(make_req(pls_pkg::K_POP, 32'd0, 5'd0));
    send_request(make_req(pls_pkg::K_DEL_END, 32'd0, 5'd0));
    send_request(make_req(pls_pkg::K_DEL_AT, 32'd0, 5'd3));
    send_request(make_req(pls_pkg::K_DUMP, 32'd0, 5'd0));
    send_request(make_req(pls_pkg::K_FIND, 32'd0, 5'd0));
  endtask

  task automatic test_insert_positions();
    send_request(make_req(pls_pkg::K_PUSH, 32'h8000_0000, 5'd31));
    send_request(make_req(pls_pkg::K_APPEND, 32'h7fff_ffff, 5'd0));
    send_request(make_req(pls_pkg::K_INSERT, 32'd5, 5'd0));
    send_request(make_req(pls_pkg::K_INSERT, 32'd6, 5'd4));
    send_request(make_req(pls_pkg::K_INSERT, 32'hffff_ffff, 5'd3));
    send_request(make_req(pls_pkg::K_INSERT, 32'd0, 5'd1));
  endtask

  task automatic test_find_peek_dump();
    send_request(make_req(pls_pkg::K_FIND, 32'h7fff_ffff, 5'd0));
    send_request(make_req(pls_pkg::K_FIND, 32'd12345, 5'd31));
    send_request(make_req(pls_pkg::K_PEEK, 32'd0, 5'd0));
    send_request(make_req(pls_pkg::K_DUMP, 32'd0, 5'd0));
  endtask

  task automatic test_delete_positions();
    send_request(make_req(pls_pkg::K_DEL_AT, 32'd0, 5'd0));
    send_request(make_req(pls_pkg::K_DEL_AT, 32'd0, 5'd5));
    send_request(make_req(pls_pkg::K_DEL_AT, 32'd0, 5'd31));
    send_request(make_req(pls_pkg::K_DEL_AT, 32'd0, 5'd2));
    send_request(make_req(pls_pkg::K_POP, 32'd0, 5'd0));
    send_request(make_req(pls_pkg::K_DEL_END, 32'd0, 5'd0));
  endtask

  task automatic test_undefined_kinds();
    send_request(make_req(pls_pkg::kind_t'(4'd9), 32'hffff_ffff, 5'd31));
    send_request(make_req(pls_pkg::kind_t'(4'd12), 32'd1, 5'd1));
    send_request(make_req(pls_pkg::kind_t'(4'd15), 32'h8000_0000, 5'd0));
  endtask

  task automatic test_full_list();
    logic signed [31:0] tail_value;
    while (shadow_count < LIST_DEPTH) begin
      send_request(make_req(pls_pkg::K_APPEND, $urandom, 5'd0));
    end
    send_request(make_req(pls_pkg::K_PUSH, 32'd1, 5'd0));
    send_request(make_req(pls_pkg::K_APPEND, 32'd2, 5'd0));
    send_request(make_req(pls_pkg::K_INSERT, 32'd3, 5'd1));
    send_request(make_req(pls_pkg::K_INSERT, 32'd4, 5'd0));
    send_request(make_req(pls_pkg::K_DUMP, 32'd0, 5'd0));
    tail_value = shadow_list[LIST_DEPTH - 1];
    send_request(make_req(pls_pkg::K_FIND, tail_value, 5'd0));
    send_request(make_req(pls_pkg::K_DEL_AT, 32'd0, 5'(LIST_DEPTH)));
    send_request(make_req(pls_pkg::K_DEL_AT, 32'd0, 5'(LIST_DEPTH + 1)));
    while (shadow_count > 0) begin
      send_request(make_req(pls_pkg::kind_t'(shadow_count[0] ? pls_pkg::K_POP
                                                              : pls_pkg::K_DEL_END),
                            32'd0, 5'd0));
    end
    drain_results();
  endtask

  task automatic test_backpressure();
    @(negedge clk);
    hold_request = HOLD_CYCLES;
    @(posedge clk);
    gaps_on = 1'b0;
    for (int k = 0; k < 12; k++) begin
      send_request(make_req(pls_pkg::kind_t'(k[0] ? pls_pkg::K_FIND : pls_pkg::K_PUSH),
                            $urandom, 5'($urandom_range(0, 31))));
    end
    drain_results();
  endtask

  task automatic test_random_ops(input int n_items, input int grow_pct, input bit with_gaps);
    pls_pkg::request_t req;
    int                roll;
    gaps_on = with_gaps;
    burst_left = 0;
    for (int k = 0; k < n_items; k++) begin
      req.value = $urandom;
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: req.value = 32'h8000_0000;
          1: req.value = 32'h7fff_ffff;
          2: req.value = 32'd0;
          default: req.value = 32'hffff_ffff;
        endcase
      end
      req.position = 5'($urandom_range(0, 31));
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        req.kind = pls_pkg::kind_t'(4'($urandom_range(9, 15)));
      end else if (roll < 74) begin
        if ($urandom_range(0, 99) < grow_pct) begin
          case ($urandom_range(0, 2))
            0: req.kind = pls_pkg::K_PUSH;
            1: req.kind = pls_pkg::K_APPEND;
            default: req.kind = pls_pkg::K_INSERT;
          endcase
          if ($urandom_range(0, 3) != 0) req.position = 5'($urandom_range(1, shadow_count + 1));
        end else begin
          case ($urandom_range(0, 2))
            0: req.kind = pls_pkg::K_POP;
            1: req.kind = pls_pkg::K_DEL_END;
            default: req.kind = pls_pkg::K_DEL_AT;
          endcase
          if (shadow_count > 0 && $urandom_range(0, 3) != 0) begin
            req.position = 5'($urandom_range(1, shadow_count));
          end
        end
      end else if (roll < 88) begin
        req.kind = pls_pkg::K_FIND;
        if (shadow_count > 0 && $urandom_range(0, 9) < 6) begin
          req.value = shadow_list[$urandom_range(0, shadow_count - 1)];
        end
      end else if (roll < 94) begin
        req.kind = pls_pkg::K_PEEK;
      end else begin
        req.kind = pls_pkg::K_DUMP;
      end
      send_request(req);
    end
    drain_results();
  endtask

  always @(posedge clk) begin
    stall_tick = stall_tick + 1;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (hold_request > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_request - 1;
      hold_request = 0;
    end else begin
      case ((stall_tick / 40) % 4)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 99) < 30);
        2: out_stall <= ($urandom_range(0, 99) < 75);
        default: out_stall <= stall_tick[1];
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    pls_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $error("result with no request waiting: status %0d data_out %0d",
               out_data.status, out_data.data_out);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data.status);
          mismatches++;
        end
        if (out_data.data_out !== want.data_out) begin
          $error("data_out: expected %0d, actual %0d", want.data_out, out_data.data_out);
          mismatches++;
        end
        if (out_data.index_out !== want.index_out) begin
          $error("index_out: expected %0d, actual %0d", want.index_out, out_data.index_out);
          mismatches++;
        end
        if (out_data.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, actual %0d",
                 want.entry_count, out_data.entry_count);
          mismatches++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_data.last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_insert_positions();
    test_find_peek_dump();
    test_delete_positions();
    test_undefined_kinds();
    drain_results();
    test_full_list();
    test_backpressure();
    test_random_ops(85, 75, 1'b1);
    test_random_ops(85, 25, 1'b0);
    test_random_ops(80, 50, 1'b1);
    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/pls_pkg.sv
sv/pls_cell.sv
sv/positional_list_stack_core.sv
sim/tb_positional_list_stack_core.sv
